/* sv/lcfa_pkg.sv */
// Shared constants, types and state codes for the loop current flow averager.
// Used by every module of the block; depends on nothing.
package lcfa_pkg;

   // Window and converter geometry.
   localparam int WINDOW_LEN  = 8;
   localparam int SAMPLE_BITS = 10;

   // Fixed field and register widths.
   localparam int REG_BITS       = 10;
   localparam int CALIB_BITS     = 16;
   localparam int MEAN_OUT_BITS  = 10;
   localparam int FLOW_BITS      = 27;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam int ZC_BITS        = 5;
   localparam int SCALE_BITS     = 17;

   // Derived widths.
   localparam int SUM_BITS   = SAMPLE_BITS + $clog2(WINDOW_LEN);
   localparam int CMP_BITS   = (SAMPLE_BITS > REG_BITS) ? SAMPLE_BITS : REG_BITS;
   localparam int PROD_BITS  = CMP_BITS + SCALE_BITS;
   localparam int QCMP_BITS  = (PROD_BITS > FLOW_BITS) ? PROD_BITS : FLOW_BITS;
   localparam int SUM_ALIGN  = PROD_BITS - SUM_BITS;
   localparam int DCNT_BITS  = $clog2(PROD_BITS + 1);
   localparam int MCNT_BITS  = $clog2(CMP_BITS + 1);

   // Arithmetic constants.
   localparam logic [SCALE_BITS-1:0] FLOW_SCALE  = SCALE_BITS'(100000);
   localparam logic [FLOW_BITS-1:0]  FLOW_MAX    = '1;
   localparam logic [ZC_BITS-1:0]    ZERO_LIMIT  = ZC_BITS'(20);
   localparam logic [ZC_BITS-1:0]    ZC_CEILING  = ZC_BITS'(21);
   localparam logic [REG_BITS-1:0]   LIMIT_RESET = REG_BITS'(1023);

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OFFSET       = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CALIB        = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SAMPLE_LIMIT = CSR_INDEX_BITS'(2);

   // Start command for the serial divider.
   typedef struct packed {
      logic                 start;
      logic [DCNT_BITS-1:0] steps;
   } div_req_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MEAN_START,
      ST_MEAN_WAIT,
      ST_MUL_WAIT,
      ST_DIV_WAIT,
      ST_RESULT
   } state_type;

endpackage

/* sv/lcfa_window.sv */
// Sample window: a shift line of the last accepted readings with a running sum.
// Depends on lcfa_pkg.
module lcfa_window (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  logic [lcfa_pkg::SAMPLE_BITS-1:0]  sample,
   output logic [lcfa_pkg::SUM_BITS-1:0]     sum
);
   import lcfa_pkg::*;

   logic [SAMPLE_BITS-1:0] win_ff [WINDOW_LEN];
   logic [SAMPLE_BITS-1:0] win_in [WINDOW_LEN];
   logic [SUM_BITS-1:0]    sum_ff;
   logic [SUM_BITS-1:0]    sum_in;

   always_comb begin
      win_in[0] = sample;
      for (int i = 1; i < WINDOW_LEN; i++) begin
         win_in[i] = win_ff[i-1];
      end
      // The oldest reading leaves as the new one enters.
      sum_in = sum_ff + SUM_BITS'(sample) - SUM_BITS'(win_ff[WINDOW_LEN-1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_LEN; i++) begin
            win_ff[i] <= '0;
         end
         sum_ff <= '0;
      end else if (push) begin
         for (int i = 0; i < WINDOW_LEN; i++) begin
            win_ff[i] <= win_in[i];
         end
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

/* sv/lcfa_smul.sv */
// Bit-serial multiplier by the flow scale constant, operand taken MSB first.
// Depends on lcfa_pkg.
module lcfa_smul (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [lcfa_pkg::CMP_BITS-1:0]    operand,
   output logic                             done,
   output logic [lcfa_pkg::PROD_BITS-1:0]   product
);
   import lcfa_pkg::*;

   logic [CMP_BITS-1:0]  op_ff;
   logic [CMP_BITS-1:0]  op_in;
   logic [PROD_BITS-1:0] acc_ff;
   logic [PROD_BITS-1:0] acc_in;
   logic [MCNT_BITS-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;

   always_comb begin
      op_in  = {op_ff[CMP_BITS-2:0], 1'b0};
      acc_in = {acc_ff[PROD_BITS-2:0], 1'b0}
             + (op_ff[CMP_BITS-1] ? PROD_BITS'(FLOW_SCALE) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= MCNT_BITS'(CMP_BITS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - MCNT_BITS'(1);
            if (cnt_ff == MCNT_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         op_ff  <= operand;
         acc_ff <= '0;
      end else if (busy_ff) begin
         op_ff  <= op_in;
         acc_ff <= acc_in;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

/* sv/lcfa_sdiv.sv */
// Restoring serial divider, one quotient bit per cycle, shared by the mean
// and the flow computation. Depends on lcfa_pkg.
module lcfa_sdiv (
   input  logic                              clock,
   input  logic                              reset,
   input  lcfa_pkg::div_req_type             req,
   input  logic [lcfa_pkg::PROD_BITS-1:0]    dividend,
   input  logic [lcfa_pkg::CALIB_BITS-1:0]   divisor,
   output logic                              done,
   output logic [lcfa_pkg::PROD_BITS-1:0]    quotient
);
   import lcfa_pkg::*;

   // The dividend arrives aligned to the top of quo_ff; quotient bits fill
   // in from the bottom as the dividend bits shift out of the top.
   logic [PROD_BITS-1:0]  quo_ff;
   logic [PROD_BITS-1:0]  quo_in;
   logic [CALIB_BITS-1:0] rem_ff;
   logic [CALIB_BITS-1:0] rem_in;
   logic [CALIB_BITS-1:0] dvs_ff;
   logic [CALIB_BITS:0]   trial;
   logic [CALIB_BITS:0]   diff;
   logic                  fits;
   logic [DCNT_BITS-1:0]  cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;

   always_comb begin
      trial  = {rem_ff, quo_ff[PROD_BITS-1]};
      diff   = trial - {1'b0, dvs_ff};
      fits   = trial >= {1'b0, dvs_ff};
      rem_in = fits ? diff[CALIB_BITS-1:0] : trial[CALIB_BITS-1:0];
      quo_in = {quo_ff[PROD_BITS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= req.steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - DCNT_BITS'(1);
            if (cnt_ff == DCNT_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* sv/loop_current_flow_averager.sv */
// Loop current flow averager: top level with configuration registers, sequencer
// and result register. Depends on lcfa_pkg, lcfa_window, lcfa_smul, lcfa_sdiv.
//
// Each request carries one converter reading. A reading at or above the sample
// limit is answered with zero mean and flow, and a new request is taken only
// once the result of the last one is loaded into the output register. An accepted
// reading enters the window and its mean is found by the serial divider, one bit
// per cycle; when the mean is above the offset register and the calibration
// register is nonzero, the offset-corrected mean is multiplied bit-serially by
// 100000 and divided by the calibration value in the same divider. A finished
// result waits in the output register while the next request is taken. Registers
// must be written only while the block is idle.
module loop_current_flow_averager (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [lcfa_pkg::SAMPLE_BITS-1:0]      req_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_sample_taken,
   output logic [lcfa_pkg::MEAN_OUT_BITS-1:0]    rsp_window_mean,
   output logic [lcfa_pkg::FLOW_BITS-1:0]        rsp_flow_rate,
   output logic                                  rsp_flow_error,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lcfa_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [lcfa_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import lcfa_pkg::*;

   state_type              state_ff;
   state_type              state_in;

   logic [REG_BITS-1:0]    offset_ff;
   logic [CALIB_BITS-1:0]  calib_ff;
   logic [REG_BITS-1:0]    limit_ff;

   logic                   accept;
   logic                   reject;
   logic                   push;
   logic                   mul_start;
   logic                   out_load;
   div_req_type            div_req;
   logic [PROD_BITS-1:0]   div_dividend;
   logic [CALIB_BITS-1:0]  div_divisor;
   logic                   div_done;
   logic [PROD_BITS-1:0]   div_quo;
   logic                   mul_done;
   logic [PROD_BITS-1:0]   product;
   logic [SUM_BITS-1:0]    sum;

   logic [SAMPLE_BITS-1:0] mean_q;
   logic                   flow_go;
   logic [CMP_BITS-1:0]    diff;
   logic [FLOW_BITS-1:0]   flow_sat;

   logic                   taken_ff;
   logic [SAMPLE_BITS-1:0] mean_ff;
   logic                   flow_go_ff;
   logic [FLOW_BITS-1:0]   flow_ff;
   logic [ZC_BITS-1:0]     zero_count_ff;
   logic [ZC_BITS-1:0]     zero_count_in;
   logic                   error_ff;
   logic                   error_in;

   logic                   rsp_valid_ff;
   logic                   rsp_taken_ff;
   logic [MEAN_OUT_BITS-1:0] rsp_mean_ff;
   logic [FLOW_BITS-1:0]   rsp_flow_ff;
   logic                   rsp_error_ff;

   lcfa_window u_window (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .sample (req_sample),
      .sum    (sum)
   );

   lcfa_smul u_smul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .operand (diff),
      .done    (mul_done),
      .product (product)
   );

   lcfa_sdiv u_sdiv (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         calib_ff  <= '0;
         limit_ff  <= LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_OFFSET:       offset_ff <= csr_wdata[REG_BITS-1:0];
            CSR_CALIB:        calib_ff  <= csr_wdata[CALIB_BITS-1:0];
            CSR_SAMPLE_LIMIT: limit_ff  <= csr_wdata[REG_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Datapath decisions.
   always_comb begin
      accept   = req_valid && !req_stall;
      reject   = CMP_BITS'(req_sample) >= CMP_BITS'(limit_ff);
      mean_q   = div_quo[SAMPLE_BITS-1:0];
      flow_go  = (CMP_BITS'(mean_q) > CMP_BITS'(offset_ff)) && (calib_ff != '0);
      diff     = CMP_BITS'(mean_q) - CMP_BITS'(offset_ff);
      flow_sat = (QCMP_BITS'(div_quo) > QCMP_BITS'(FLOW_MAX)) ? FLOW_MAX
                                                             : FLOW_BITS'(div_quo);
      if (state_ff == ST_MEAN_START) begin
         div_dividend = PROD_BITS'(sum) << SUM_ALIGN;
         div_divisor  = CALIB_BITS'(WINDOW_LEN);
      end else begin
         div_dividend = product;
         div_divisor  = calib_ff;
      end
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_stall     = 1'b1;
      push          = 1'b0;
      mul_start     = 1'b0;
      out_load      = 1'b0;
      div_req.start = 1'b0;
      div_req.steps = DCNT_BITS'(PROD_BITS);
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (accept) begin
               if (reject) begin
                  state_in = ST_RESULT;
               end else begin
                  push     = 1'b1;
                  state_in = ST_MEAN_START;
               end
            end
         end
         ST_MEAN_START: begin
            div_req.start = 1'b1;
            div_req.steps = DCNT_BITS'(SUM_BITS);
            state_in      = ST_MEAN_WAIT;
         end
         ST_MEAN_WAIT: begin
            if (div_done) begin
               if (flow_go) begin
                  mul_start = 1'b1;
                  state_in  = ST_MUL_WAIT;
               end else begin
                  state_in  = ST_RESULT;
               end
            end
         end
         ST_MUL_WAIT: begin
            if (mul_done) begin
               div_req.start = 1'b1;
               state_in      = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Working values for the request in flight.
   always_ff @(posedge clock) begin
      if (accept) begin
         taken_ff   <= !reject;
         mean_ff    <= '0;
         flow_go_ff <= 1'b0;
         flow_ff    <= '0;
      end else if (state_ff == ST_MEAN_WAIT && div_done) begin
         mean_ff    <= mean_q;
         flow_go_ff <= flow_go;
      end else if (state_ff == ST_DIV_WAIT && div_done) begin
         flow_ff    <= flow_sat;
      end
   end

   // Zero-mean watchdog: a run of zero means past the limit sets the error flag.
   always_comb begin
      zero_count_in = zero_count_ff;
      error_in      = error_ff;
      if (taken_ff) begin
         if (flow_go_ff) begin
            zero_count_in = '0;
            error_in      = 1'b0;
         end else if (mean_ff == '0) begin
            zero_count_in = zero_count_ff + ZC_BITS'(1);
            if (zero_count_ff > ZERO_LIMIT) begin
               error_in      = 1'b1;
               zero_count_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_count_ff <= '0;
         error_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (out_load) begin
            zero_count_ff <= zero_count_in;
            error_ff      <= error_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_taken_ff <= taken_ff;
         rsp_mean_ff  <= MEAN_OUT_BITS'(mean_ff);
         rsp_flow_ff  <= flow_ff;
         rsp_error_ff <= error_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_taken = rsp_taken_ff;
   assign rsp_window_mean  = rsp_mean_ff;
   assign rsp_flow_rate    = rsp_flow_ff;
   assign rsp_flow_error   = rsp_error_ff;

   // Checks.
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ST_IDLE))
      else $error("accepted request did not start the sequencer");

   a_reject_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_sample_taken) |-> (rsp_window_mean == '0 && rsp_flow_rate == '0))
      else $error("rejected request reported a nonzero mean or flow");

   a_flow_clears_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_flow_rate != '0) |-> !rsp_flow_error)
      else $error("nonzero flow reported with error flag set");

   a_zero_count_bound: assert property (@(posedge clock) disable iff (reset)
      zero_count_ff <= ZC_CEILING)
      else $error("zero counter ran past its wrap point");

endmodule
